[design/rsa_pkg.sv]
// Shared types and constants for the ring slot allocator.
`default_nettype none
package rsa_pkg;

	localparam int NUM_SLOTS_DEF = 1024;
	localparam int WORD_W        = 32;
	localparam int BIT_W         = $clog2(WORD_W);

	localparam logic       MODE_ALLOC   = 1'b0;
	localparam logic       MODE_RELEASE = 1'b1;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_SIZE   = 2'd1;
	localparam logic [1:0] ST_DOUBLE = 2'd2;
	localparam logic [1:0] ST_HEAP   = 2'd3;

	localparam logic        REG_OBJECT_SIZE = 1'b0;
	localparam logic [15:0] OBJECT_SIZE_RST = 16'd16;

	localparam logic signed [22:0] CNT_MAX = 23'sh3FFFFF;
	localparam logic signed [22:0] CNT_MIN = 23'sh400000;

	typedef struct packed {
		logic        mode;
		logic [15:0] request_bytes;
		logic [9:0]  release_slot;
		logic        release_in_pool;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [9:0]         granted_slot;
		logic signed [23:0] live_count;
	} out_item_t;

endpackage
`default_nettype wire

[design/ring_slot_allocator.sv]
// Next-fit slot pool allocator: free map in word RAM, ring pointer, live counter.
// A wrong-size allocate or a heap release is answered straight from idle; a pool release
// reads its map word and then writes the slot bit back; an allocate reads and checks map
// words from the pointer on until a free slot is found or the whole map has been scanned.
// One item at a time, set by the map RAM port. After reset a clearing pass over every map word holds busy high.
// Results are strobed on done for one cycle; the receiver cannot stall.
`default_nettype none
module ring_slot_allocator
	import rsa_pkg::*;
#(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	output logic           busy,
	input  wire in_item_t  cmd,
	output logic           done,
	output out_item_t      result,
	input  wire logic      psel,
	input  wire logic      penable,
	input  wire logic      pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic           pready
);

	localparam int ROWS      = (NUM_SLOTS + WORD_W - 1) / WORD_W;
	localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int IDX_W     = ROW_W + BIT_W;
	localparam int VW        = $clog2(ROWS + 1);
	localparam int LAST_BITS = NUM_SLOTS - (ROWS - 1) * WORD_W;
	localparam logic [WORD_W-1:0] LAST_MASK =
		WORD_W'((64'd1 << LAST_BITS) - 64'd1);
	localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);
	localparam logic [VW-1:0]    VIS_LAST = VW'(ROWS);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_SLOTS - 1);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_RD    = 3'd2;
	localparam logic [2:0] S_EV    = 3'd3;

	logic [2:0]             state_q;
	logic                   op_q;
	logic [ROW_W-1:0]       row_q;
	logic [BIT_W-1:0]       bit_q;
	logic [VW-1:0]          vis_q;
	logic [IDX_W-1:0]       next_q;
	logic signed [22:0]     cnt_q;
	logic signed [22:0]     cnt_nxt;
	logic [15:0]            object_size_q;
	logic                   done_q;
	out_item_t              res_q;

	logic                   accept;
	logic                   ram_we;
	logic [WORD_W-1:0]      ram_wdata;
	logic [WORD_W-1:0]      ram_rdata;
	logic [WORD_W-1:0]      row_mask;
	logic [WORD_W-1:0]      hi_mask;
	logic [WORD_W-1:0]      pass_mask;
	logic [WORD_W-1:0]      cand;
	logic                   found;
	logic [BIT_W-1:0]       hit;
	logic [IDX_W-1:0]       hit_idx;
	logic                   rel_ok;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_OBJECT_SIZE) ? {16'd0, object_size_q} : 32'd0;
	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign done   = done_q;
	assign result = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			object_size_q <= OBJECT_SIZE_RST;
		end else if (psel && penable && pwrite && paddr[2] == REG_OBJECT_SIZE) begin
			object_size_q <= pwdata[15:0];
		end
	end

	always_comb begin
		cnt_nxt = cnt_q;
		if (cmd.mode == MODE_ALLOC) begin
			if (cnt_q != CNT_MAX) cnt_nxt = cnt_q + 23'sd1;
		end else begin
			if (cnt_q != CNT_MIN) cnt_nxt = cnt_q - 23'sd1;
		end
	end

	assign rel_ok = cmd.release_in_pool && (32'(cmd.release_slot) < 32'(NUM_SLOTS));

	// map word scan
	assign row_mask  = (row_q == ROW_LAST) ? LAST_MASK : '1;
	assign hi_mask   = {WORD_W{1'b1}} << next_q[BIT_W-1:0];
	assign pass_mask = (vis_q == '0) ? hi_mask : (vis_q == VIS_LAST) ? ~hi_mask : '1;
	assign cand      = ram_rdata & row_mask & pass_mask;
	assign found     = (cand != '0);
	assign hit_idx   = {row_q, hit};

	always_comb begin
		hit = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (cand[i]) hit = BIT_W'(i);
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_wdata = ram_rdata;
		if (state_q == S_CLEAR) begin
			ram_we    = 1'b1;
			ram_wdata = '1;
		end else if (state_q == S_EV) begin
			if (op_q == MODE_ALLOC) begin
				ram_we    = found;
				ram_wdata = ram_rdata & ~(WORD_W'(1) << hit);
			end else begin
				ram_we    = !ram_rdata[bit_q];
				ram_wdata = ram_rdata | (WORD_W'(1) << bit_q);
			end
		end
	end

	rsa_ram #(
		.WIDTH(WORD_W),
		.DEPTH(ROWS)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(row_q),
		.wdata(ram_wdata),
		.raddr(row_q),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			op_q    <= MODE_ALLOC;
			row_q   <= '0;
			bit_q   <= '0;
			vis_q   <= '0;
			next_q  <= '0;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					if (row_q == ROW_LAST) begin
						state_q <= S_IDLE;
					end else begin
						row_q <= row_q + ROW_W'(1);
					end
				end
				S_IDLE: begin
					if (accept) begin
						cnt_q <= cnt_nxt;
						op_q  <= cmd.mode;
						vis_q <= '0;
						if (cmd.mode == MODE_ALLOC) begin
							if (cmd.request_bytes != object_size_q) begin
								done_q  <= 1'b1;
							end else begin
								row_q   <= next_q[IDX_W-1:BIT_W];
								state_q <= S_RD;
							end
						end else begin
							if (rel_ok) begin
								row_q   <= ROW_W'(IDX_W'(cmd.release_slot) >> BIT_W);
								bit_q   <= cmd.release_slot[BIT_W-1:0];
								state_q <= S_RD;
							end else begin
								done_q  <= 1'b1;
							end
						end
					end
				end
				S_RD: begin
					state_q <= S_EV;
				end
				S_EV: begin
					if (op_q == MODE_RELEASE) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else if (found) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
						next_q  <= (hit_idx == IDX_LAST) ? '0 : hit_idx + IDX_W'(1);
					end else if (vis_q == VIS_LAST) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						row_q   <= (row_q == ROW_LAST) ? '0 : row_q + ROW_W'(1);
						vis_q   <= vis_q + VW'(1);
						state_q <= S_RD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && accept) begin
			res_q.granted_slot <= '0;
			res_q.live_count   <= {cnt_nxt[22], cnt_nxt};
			res_q.status       <= (cmd.mode == MODE_ALLOC) ? ST_SIZE : ST_HEAP;
		end else if (state_q == S_EV) begin
			res_q.live_count   <= {cnt_q[22], cnt_q};
			res_q.granted_slot <= '0;
			if (op_q == MODE_RELEASE) begin
				res_q.status <= ram_rdata[bit_q] ? ST_DOUBLE : ST_OK;
			end else if (found) begin
				res_q.status       <= ST_OK;
				res_q.granted_slot <= 10'(hit_idx);
			end else begin
				res_q.status <= ST_HEAP;
			end
		end
	end

endmodule
`default_nettype wire

[design/rsa_ram.sv]
// Generic single-port-write RAM with registered read.
`default_nettype none
module rsa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

[tb/ring_slot_allocator_checker.sv]
// Checker for the ring slot allocator: tracks pool state from the bus traffic and checks each result.
`default_nettype none
module ring_slot_allocator_checker
	import rsa_pkg::*;
#(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic        busy,
	input  wire in_item_t    cmd,
	input  wire logic        done,
	input  wire out_item_t   result,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	input  wire logic        pready,
	output int               errors,
	output int               outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [NUM_SLOTS-1:0] slot_free;
	int                   ring_ptr;
	logic signed [22:0]   live_objs;
	logic [15:0]          accepted_size;
	out_item_t            pending_results[$];
	int                   err_cnt;

	function automatic out_item_t serve_request(in_item_t it);
		out_item_t r;
		int pos;
		int n;
		r.status = ST_HEAP;
		r.granted_slot = '0;
		if (it.mode == MODE_ALLOC) begin
			if (live_objs < CNT_MAX)
				live_objs = live_objs + 23'sd1;
			if (it.request_bytes != accepted_size) begin
				r.status = ST_SIZE;
			end else begin
				pos = ring_ptr;
				for (n = 0; n < NUM_SLOTS; n++) begin
					if (slot_free[pos]) begin
						slot_free[pos] = 1'b0;
						r.status = ST_OK;
						r.granted_slot = pos[9:0];
						ring_ptr = (pos + 1) % NUM_SLOTS;
						break;
					end
					pos = (pos + 1) % NUM_SLOTS;
				end
			end
		end else begin
			if (live_objs > CNT_MIN)
				live_objs = live_objs - 23'sd1;
			if (it.release_in_pool && it.release_slot < NUM_SLOTS) begin
				if (slot_free[it.release_slot]) begin
					r.status = ST_DOUBLE;
				end else begin
					slot_free[it.release_slot] = 1'b1;
					r.status = ST_OK;
				end
			end
		end
		r.live_count = {live_objs[22], live_objs};
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			slot_free = '1;
			ring_ptr = 0;
			live_objs = '0;
			accepted_size = OBJECT_SIZE_RST;
			pending_results.delete();
			err_cnt = 0;
			errors <= 0;
			outstanding <= 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == {REG_OBJECT_SIZE, 2'b00})
				accepted_size = pwdata[15:0];
			if (start && !busy)
				pending_results.push_back(serve_request(cmd));
			if (done) begin
				if (pending_results.size() == 0) begin
					err_cnt++;
					$error("result with no item outstanding: status %0d slot %0d count %0d",
						result.status, result.granted_slot, result.live_count);
				end else begin
					want = pending_results.pop_front();
					if (result.status !== want.status) begin
						err_cnt++;
						$error("status: expected %0d, got %0d", want.status, result.status);
					end
					if (result.granted_slot !== want.granted_slot) begin
						err_cnt++;
						$error("granted_slot: expected %0d, got %0d",
							want.granted_slot, result.granted_slot);
					end
					if (result.live_count !== want.live_count) begin
						err_cnt++;
						$error("live_count: expected %0d, got %0d",
							want.live_count, result.live_count);
					end
				end
			end
			errors <= err_cnt;
			outstanding <= pending_results.size();
		end
	end

endmodule
`default_nettype wire

[tb/tb_ring_slot_allocator.sv]
// Testbench top for the ring slot allocator: clock, reset, register writes and item stimulus.
`default_nettype none
module tb_ring_slot_allocator
	import rsa_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_WAIT  = 2 * (NUM_SLOTS_DEF / WORD_W + 1) + 4;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	in_item_t    cmd;
	logic        done;
	out_item_t   result;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	int          errors;
	int          outstanding;

	logic [15:0] size_now;
	logic [9:0]  held_slots[$];
	logic        last_mode;
	logic        pool_full_seen;
	int          cycles;

	ring_slot_allocator dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.done(done), .result(result), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	ring_slot_allocator_checker checker_i (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.done(done), .result(result), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .pready(pready),
		.errors(errors), .outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb_ring_slot_allocator: FAIL");
			$finish;
		end
	end

	// slots granted and not yet released, used to pick meaningful releases; also notes a heap spill
	initial pool_full_seen = 1'b0;
	always @(posedge clk) begin
		if (start && !busy)
			last_mode <= cmd.mode;
		if (done && last_mode == MODE_ALLOC) begin
			if (result.status == ST_OK)
				held_slots.push_back(result.granted_slot);
			if (result.status == ST_HEAP)
				pool_full_seen <= 1'b1;
		end
	end

	task automatic issue(input logic m, input logic [15:0] bytes, input logic [9:0] slot,
		input logic in_pool);
		cmd <= in_item_t'{m, bytes, slot, in_pool};
		start <= 1'b1;
		do @(posedge clk); while (busy);
	endtask

	task automatic pause(input bit calm);
		if (!calm && $urandom_range(99) < 22) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic write_size(input logic [15:0] value);
		drain();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_OBJECT_SIZE, 2'b00};
		pwdata <= {16'($urandom), value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		size_now = value;
	endtask

	task automatic random_phase(input int count, input int alloc_pct, input int calm_from,
		input int calm_to);
		int i;
		int idx;
		int pick;
		logic [9:0] slot;
		for (i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			if (pick < alloc_pct) begin
				issue(MODE_ALLOC, size_now, 10'($urandom), 1'($urandom));
			end else if (pick < alloc_pct + 5) begin
				issue(MODE_ALLOC, 16'($urandom), 10'($urandom), 1'($urandom));
			end else if (pick < 90 && held_slots.size() != 0) begin
				idx = $urandom_range(held_slots.size() - 1);
				slot = held_slots[idx];
				held_slots.delete(idx);
				issue(MODE_RELEASE, 16'($urandom), slot, 1'b1);
			end else if (pick < 95) begin
				issue(MODE_RELEASE, 16'($urandom), 10'($urandom), 1'b1);
			end else begin
				issue(MODE_RELEASE, 16'($urandom), 10'($urandom), 1'b0);
			end
			if (i == count / 2 || $urandom_range(299) == 0)
				drain();
			else
				pause(i >= calm_from && i < calm_to);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		size_now = OBJECT_SIZE_RST;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// reset size, sizes off by one and at the field limits, double and heap frees
		issue(MODE_ALLOC, 16'd16, 10'd0, 1'b0);              pause(0);
		issue(MODE_ALLOC, 16'd16, 10'h3FF, 1'b1);            pause(0);
		issue(MODE_ALLOC, 16'd15, 10'd0, 1'b0);              pause(0);
		issue(MODE_ALLOC, 16'd0, 10'd0, 1'b0);               pause(0);
		issue(MODE_ALLOC, 16'hFFFF, 10'h3FF, 1'b1);          pause(0);
		issue(MODE_RELEASE, 16'd0, 10'd0, 1'b1);             pause(0);
		issue(MODE_RELEASE, 16'hFFFF, 10'd0, 1'b1);          pause(0);
		issue(MODE_RELEASE, 16'd0, 10'h3FF, 1'b1);           pause(0);
		issue(MODE_RELEASE, 16'hFFFF, 10'h3FF, 1'b0);        pause(0);
		issue(MODE_RELEASE, 16'd0, 10'd0, 1'b0);             pause(0);
		issue(MODE_ALLOC, 16'd16, 10'd0, 1'b0);              pause(0);
		issue(MODE_RELEASE, 16'd0, 10'd1, 1'b1);             pause(0);
		issue(MODE_RELEASE, 16'd0, 10'd2, 1'b1);             pause(0);
		write_size(16'd1);
		issue(MODE_ALLOC, 16'd1, 10'd0, 1'b0);               pause(0);
		issue(MODE_ALLOC, 16'd16, 10'd0, 1'b0);              pause(0);
		issue(MODE_ALLOC, 16'd2, 10'd0, 1'b0);               pause(0);
		issue(MODE_RELEASE, 16'd1, 10'd3, 1'b1);             pause(0);
		write_size(16'hFFFF);
		issue(MODE_ALLOC, 16'hFFFF, 10'd0, 1'b0);            pause(0);
		issue(MODE_ALLOC, 16'hFFFE, 10'd0, 1'b0);            pause(0);
		issue(MODE_RELEASE, 16'hFFFF, 10'd4, 1'b1);          pause(0);

		write_size(16'($urandom_range(2, 65534)));
		random_phase(200, 50, 60, 140);

		// fill the pool until allocation spills to the heap
		write_size(16'd1);
		while (!pool_full_seen)
			issue(MODE_ALLOC, size_now, 10'($urandom), 1'($urandom));
		issue(MODE_ALLOC, size_now, 10'($urandom), 1'($urandom));
		issue(MODE_ALLOC, size_now, 10'($urandom), 1'($urandom));

		write_size(16'hFFFF);
		random_phase(100, 25, 0, 0);
		random_phase(100, 55, 0, 0);

		drain();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (errors == 0 && outstanding == 0)
			$display("tb_ring_slot_allocator: PASS");
		else
			$display("tb_ring_slot_allocator: FAIL");
		$finish;
	end

endmodule
`default_nettype wire
